// ===== rtl/core/iqd_pkg.sv =====
// iqd_pkg: types, constants and helpers shared by the iq packet deframer
// no dependencies

package iqd_pkg;

	localparam int HDR_BYTES = 28;
	localparam int HDR_CNT_W = $clog2(HDR_BYTES);

	localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

	localparam logic [31:0] MAGIC_WORD   = 32'h000E_B200;
	localparam logic [15:0] MAJOR_VER    = 16'd2;
	localparam logic [15:0] STREAM_TAG   = 16'd901;
	localparam logic [15:0] MINOR_ALT    = 16'd97;
	localparam int          SWAP_BIT     = 5;

	localparam int POS_MAGIC = 0;
	localparam int POS_MINOR = 4;
	localparam int POS_MAJOR = 6;
	localparam int POS_SEQ   = 8;
	localparam int POS_TAG   = 16;
	localparam int POS_LEN   = 18;
	localparam int POS_ITEMS = 20;
	localparam int POS_FLAGS = 24;

	localparam logic STATUS_SAMPLE = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_SKIP    = 3'b100
	} phase_t;

	typedef struct packed {
		logic               status;
		logic signed [15:0] i_value;
		logic signed [15:0] q_value;
		logic               first_sample;
		logic               sequence_break;
		logic               last_sample;
	} result_t;

	typedef struct packed {
		logic        match;
		logic        seq_break;
		logic        fmt_ok;
		logic        wide;
		logic        swap;
		logic        minor_alt;
		logic [15:0] seq;
		logic [15:0] items;
	} hdr_chk_t;

	function automatic logic [15:0] pair(input logic [7:0] hi, input logic [7:0] lo,
		input logic swap);
		pair = swap ? {lo, hi} : {hi, lo};
	endfunction

endpackage

// ===== rtl/core/iqd_byte_if.sv =====
// iqd_byte_if: byte channel into the deframer, valid/ready handshake
// depends on nothing

interface iqd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// ===== rtl/core/iqd_sample_if.sv =====
// iqd_sample_if: result channel out of the deframer, valid/ready handshake
// depends on nothing

interface iqd_sample_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [15:0] i_value;
	logic signed [15:0] q_value;
	logic               first_sample;
	logic               sequence_break;
	logic               last_sample;

	modport source (output valid, output status, output i_value, output q_value,
		output first_sample, output sequence_break, output last_sample, input ready);
	modport sink   (input valid, input status, input i_value, input q_value,
		input first_sample, input sequence_break, input last_sample, output ready);
endinterface

// ===== rtl/core/iqd_hdr_check.sv =====
// iqd_hdr_check: header byte store and registered field checks
// depends on iqd_pkg

module iqd_hdr_check
	import iqd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [HDR_CNT_W-1:0] wr_idx,
	input  logic [7:0]           wr_data,
	input  logic [15:0]          prev_seq,
	output hdr_chk_t             chk
);

	logic [7:0]  store_q [HDR_BYTES];
	logic [18:0] items5_s1;
	logic [19:0] items9_s1;
	logic [15:0] len_s1;
	logic [15:0] items_s1;
	hdr_chk_t    chk_d;
	hdr_chk_t    chk_s2;

	logic [15:0] seq_w;
	logic [15:0] items_w;
	logic [15:0] len_w;
	logic [19:0] len_x;
	logic [19:0] items4_x;
	logic [19:0] items8_x;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= wr_data;
		end
	end

	assign seq_w   = {store_q[POS_SEQ], store_q[POS_SEQ+1]};
	assign items_w = {store_q[POS_ITEMS], store_q[POS_ITEMS+1]};
	assign len_w   = {store_q[POS_LEN], store_q[POS_LEN+1]};

	// first stage: item count times five and nine
	always_ff @(posedge clk) begin
		items5_s1 <= {1'b0, items_w, 2'b00} + {3'b000, items_w};
		items9_s1 <= {1'b0, items_w, 3'b000} + {4'b0000, items_w};
		len_s1    <= len_w;
		items_s1  <= items_w;
	end

	assign len_x    = {4'b0000, len_s1};
	assign items4_x = {2'b00, items_s1, 2'b00};
	assign items8_x = {1'b0, items_s1, 3'b000};

	always_comb begin
		chk_d.match = ({store_q[POS_MAGIC], store_q[POS_MAGIC+1],
			store_q[POS_MAGIC+2], store_q[POS_MAGIC+3]} == MAGIC_WORD)
			&& ({store_q[POS_MAJOR], store_q[POS_MAJOR+1]} == MAJOR_VER)
			&& ({store_q[POS_TAG], store_q[POS_TAG+1]} == STREAM_TAG);
		chk_d.seq_break = (seq_w != (prev_seq + 16'd1));
		chk_d.wide      = (len_x >= items8_x) && (len_x < items9_s1);
		chk_d.fmt_ok    = ((len_x >= items4_x) && (len_x < {1'b0, items5_s1}))
			|| chk_d.wide;
		chk_d.swap      = store_q[POS_FLAGS][SWAP_BIT];
		chk_d.minor_alt = ({store_q[POS_MINOR], store_q[POS_MINOR+1]} == MINOR_ALT);
		chk_d.seq       = seq_w;
		chk_d.items     = items_s1;
	end

	// second stage: compare results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s2 <= '0;
		end else begin
			chk_s2 <= chk_d;
		end
	end

	assign chk = chk_s2;

endmodule

// ===== rtl/core/iqd_parser.sv =====
// iqd_parser: packet phase control, sample assembly and result forming
// depends on iqd_pkg and the checks from iqd_hdr_check

module iqd_parser
	import iqd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_packet,
	input  hdr_chk_t             chk,
	output logic                 hdr_wr,
	output logic [HDR_CNT_W-1:0] hdr_idx,
	output logic [15:0]          prev_seq,
	output logic                 res_valid,
	output result_t              res
);

	phase_t               phase_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [15:0]          prev_seq_q;
	logic [15:0]          expected_q;
	logic [15:0]          done_q;
	logic [7:0]           sbytes_q [8];
	logic [2:0]           sbc_q;
	logic                 wide_q;
	logic                 swap_q;
	logic                 minor_alt_q;
	logic                 brk_pend_q;

	logic        sample_done;
	logic [15:0] done_nxt;
	logic        is_first;
	logic        is_last;
	logic [15:0] i_w;
	logic [15:0] q_w;

	assign hdr_wr   = acc && (phase_q == PH_HUNT);
	assign hdr_idx  = hdr_cnt_q;
	assign prev_seq = prev_seq_q;

	assign sample_done = wide_q ? (sbc_q == 3'd7) : (sbc_q == 3'd3);
	assign done_nxt    = done_q + 16'd1;
	assign is_first    = (done_q == 16'd0);
	assign is_last     = (done_nxt == expected_q);

	always_comb begin
		if (!wide_q) begin
			i_w = pair(sbytes_q[0], sbytes_q[1], swap_q);
			q_w = pair(sbytes_q[2], data_byte, swap_q);
		end else if (minor_alt_q) begin
			i_w = pair(sbytes_q[1], sbytes_q[2], swap_q);
			q_w = pair(sbytes_q[5], sbytes_q[6], swap_q);
		end else begin
			i_w = pair(sbytes_q[2], sbytes_q[3], swap_q);
			q_w = pair(sbytes_q[6], data_byte, swap_q);
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (acc) begin
			case (phase_q)
				PH_HUNT: begin
					if (hdr_cnt_q == HDR_LAST) begin
						if (!chk.match || !chk.fmt_ok) begin
							res_valid  = 1'b1;
							res.status = STATUS_REJECT;
						end
					end else if (end_of_packet) begin
						res_valid  = 1'b1;
						res.status = STATUS_REJECT;
					end
				end
				PH_PAYLOAD: begin
					if (sample_done) begin
						res_valid          = 1'b1;
						res.status         = STATUS_SAMPLE;
						res.i_value        = i_w;
						res.q_value        = q_w;
						res.first_sample   = is_first;
						res.sequence_break = is_first && brk_pend_q;
						res.last_sample    = is_last;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (phase_q == PH_PAYLOAD)) begin
			sbytes_q[sbc_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			hdr_cnt_q   <= '0;
			prev_seq_q  <= '0;
			expected_q  <= '0;
			done_q      <= '0;
			sbc_q       <= '0;
			wide_q      <= 1'b0;
			swap_q      <= 1'b0;
			minor_alt_q <= 1'b0;
			brk_pend_q  <= 1'b0;
		end else if (acc) begin
			case (phase_q)
				PH_HUNT: begin
					if (hdr_cnt_q == HDR_LAST) begin
						hdr_cnt_q <= '0;
						if (!chk.match) begin
							phase_q <= end_of_packet ? PH_HUNT : PH_SKIP;
						end else begin
							prev_seq_q <= chk.seq;
							brk_pend_q <= chk.seq_break;
							if (!chk.fmt_ok) begin
								phase_q <= end_of_packet ? PH_HUNT : PH_SKIP;
							end else begin
								wide_q      <= chk.wide;
								swap_q      <= chk.swap;
								minor_alt_q <= chk.minor_alt;
								expected_q  <= chk.items;
								done_q      <= '0;
								sbc_q       <= '0;
								phase_q     <= end_of_packet ? PH_HUNT : PH_PAYLOAD;
							end
						end
					end else if (end_of_packet) begin
						hdr_cnt_q <= '0;
					end else begin
						hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
					end
				end
				PH_PAYLOAD: begin
					if (sample_done) begin
						sbc_q  <= '0;
						done_q <= done_nxt;
					end else begin
						sbc_q <= sbc_q + 3'd1;
					end
					if (end_of_packet) begin
						phase_q <= PH_HUNT;
						sbc_q   <= '0;
					end else if (sample_done && is_last) begin
						phase_q <= PH_SKIP;
					end
				end
				default: begin
					phase_q <= end_of_packet ? PH_HUNT : PH_SKIP;
				end
			endcase
		end
	end

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HDR_LAST)
		else $error("header byte count out of range");

	a_narrow_sbc: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD && !wide_q) |-> sbc_q <= 3'd3)
		else $error("short sample byte count overran");

	a_hdr_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_packet) |=> (hdr_cnt_q == '0 && phase_q != PH_SKIP
			&& sbc_q == 3'd0))
		else $error("packet end did not return parser to a clean start");

endmodule

// ===== rtl/core/iqd_out_skid.sv =====
// iqd_out_skid: result register with one skid entry toward the receiver
// depends on iqd_pkg

module iqd_out_skid
	import iqd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    can_accept,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;

	assign can_accept = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in front");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("item pushed while skid entry full");

endmodule

// ===== rtl/core/iq_packet_deframer.sv =====
// iq_packet_deframer: top level of the iq packet deframer
// depends on iqd_pkg, iqd_byte_if, iqd_sample_if, iqd_hdr_check, iqd_parser, iqd_out_skid
//
// in_ch carries datagram bytes, end_of_packet high on the last byte of each.
// a 28-byte header is checked (magic, major version, tag, size per item) and
// every completed sample gives one item on out_ch with signed i/q values and
// first, last and sequence break marks; a rejected packet or one that ends within its
// header gives one item with status high, after which the rest of the packet is dropped.
// throughput: one byte per cycle while in_ch.ready is high; header field checks
// run two register stages behind the header byte store, ready long before the
// last header byte. each result is registered before it is valid on out_ch.
// the result register has one skid entry behind it, so bytes keep flowing while
// one result waits; in_ch.ready drops whenever the skid entry holds a result.
// reset clears the phase to header hunting, all counters and the previous
// sequence number; the byte stores need no clearing.

module iq_packet_deframer
	import iqd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	iqd_byte_if.sink            in_ch,
	iqd_sample_if.source        out_ch
);

	logic                 acc;
	logic                 can_accept;
	logic                 hdr_wr;
	logic [HDR_CNT_W-1:0] hdr_idx;
	logic [15:0]          prev_seq;
	hdr_chk_t             chk;
	logic                 res_valid;
	result_t              res;
	result_t              out_data;

	assign in_ch.ready = can_accept;
	assign acc         = in_ch.valid && can_accept;

	iqd_hdr_check u_hdr_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (hdr_wr),
		.wr_idx   (hdr_idx),
		.wr_data  (in_ch.data_byte),
		.prev_seq (prev_seq),
		.chk      (chk)
	);

	iqd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.data_byte     (in_ch.data_byte),
		.end_of_packet (in_ch.end_of_packet),
		.chk           (chk),
		.hdr_wr        (hdr_wr),
		.hdr_idx       (hdr_idx),
		.prev_seq      (prev_seq),
		.res_valid     (res_valid),
		.res           (res)
	);

	iqd_out_skid u_out_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.can_accept (can_accept),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_data   (out_data)
	);

	assign out_ch.status         = out_data.status;
	assign out_ch.i_value        = out_data.i_value;
	assign out_ch.q_value        = out_data.q_value;
	assign out_ch.first_sample   = out_data.first_sample;
	assign out_ch.sequence_break = out_data.sequence_break;
	assign out_ch.last_sample    = out_data.last_sample;

endmodule
